// ----- src/rdsps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsps_pkg
// Shared types and constants for the RDS program service name assembler.
// ----------------------------------------------------------------------------
package rdsps_pkg;

    localparam int NAME_LEN  = 8;
    localparam int SEG_W     = 2;
    localparam int POS_W     = 3;
    localparam int CHAR_W    = 8;
    localparam int NAME_W    = NAME_LEN * CHAR_W;
    localparam int BLOCK_W   = 16;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [SEG_W-1:0]  SEG_MASK   = 2'h3;
    localparam logic [3:0]        GROUP_TYPE_0 = 4'h0;

    typedef enum logic {
        OP_GROUP  = 1'b0,
        OP_RETUNE = 1'b1
    } opcode_t;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [NAME_LEN-1:0][CHAR_W-1:0] char_arr_t;

    typedef struct packed {
        char_arr_t pending;
        char_arr_t confirmed;
        logic      seen;
    } ps_state_t;

    typedef struct packed {
        logic [NAME_W-1:0] station_name;
        logic              name_valid;
        logic              group_used;
    } ps_result_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [BLOCK_W-1:0]  block_b;
        logic [BLOCK_W-1:0]  block_d;
    } ps_item_t;

endpackage

// ----- src/rds_station_name_assembler_core.sv -----
`timescale 1ns / 1ps
// path: an accepted input word is held in the input register, and its result word in the output register
// throughput: one word per cycle, limited only by the output side taking words
// the output register lets the next word be accepted while a result waits
// reset: asynchronous, clears both stage valids, name to spaces, candidates to zero
// ----------------------------------------------------------------------------
// rds_station_name_assembler_core
// Builds the 8-character program service name from type 0 RDS groups.
// ----------------------------------------------------------------------------
module rds_station_name_assembler_core
    import rdsps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // block_b[15:0], block_d[31:16]
    input  logic [0:0]   s_axis_tuser,   // opcode[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // station_name[63:0]
    output logic [1:0]   m_axis_tuser    // name_valid[0], group_used[1]
);

    logic       in_valid_reg;
    ps_item_t   in_item_reg;
    logic       out_valid_reg;
    ps_result_t out_result_reg;
    ps_state_t  state_reg;
    ps_state_t  state_next;
    ps_result_t result_next;
    logic       advance;
    ps_state_t  state_init;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;

    always_comb
    begin
        for (int i = 0; i < NAME_LEN; i++)
        begin
            state_init.pending[i]   = '0;
            state_init.confirmed[i] = SPACE_CHAR;
        end
        state_init.seen = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.opcode  <= opcode_t'(s_axis_tuser[0]);
            in_item_reg.block_b <= s_axis_tdata[BLOCK_W-1:0];
            in_item_reg.block_d <= s_axis_tdata[2*BLOCK_W-1:BLOCK_W];
        end
    end

    rdsps_update u_update (
        .item       (in_item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= state_init;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_result_reg.station_name;
    assign m_axis_tuser[0] = out_result_reg.name_valid;
    assign m_axis_tuser[1] = out_result_reg.group_used;

endmodule

// ----- src/rdsps_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsps_update
// Per-word character update: two-in-a-row confirmation, retune clear,
// and packing of the confirmed name.
// ----------------------------------------------------------------------------
module rdsps_update
    import rdsps_pkg::*;
(
    input  ps_item_t   item,
    input  ps_state_t  state_cur,
    output ps_state_t  state_next,
    output ps_result_t result
);

    logic             do_group;
    logic [SEG_W-1:0] seg;
    char_t            ch_hi;
    char_t            ch_lo;

    assign do_group = (item.opcode == OP_GROUP)
                   && (item.block_b[BLOCK_W-1 -: 4] == GROUP_TYPE_0);
    assign seg   = item.block_b[SEG_W-1:0] & SEG_MASK;
    assign ch_hi = item.block_d[BLOCK_W-1 -: CHAR_W];
    assign ch_lo = item.block_d[CHAR_W-1:0];

    always_comb
    begin
        logic [POS_W-1:0] pos;
        char_t            ch;
        logic             hit;
        state_next = state_cur;
        for (int i = 0; i < NAME_LEN; i++)
        begin
            pos = POS_W'(i);
            // even positions take the high byte, odd ones the low byte
            ch  = pos[0] ? ch_lo : ch_hi;
            hit = do_group && (pos[POS_W-1:1] == seg);
            if (hit)
            begin
                if (state_cur.pending[i] == ch)
                begin
                    state_next.confirmed[i] = ch;
                    state_next.seen         = 1'b1;
                end
                else
                begin
                    state_next.pending[i] = ch;
                end
            end
        end
        if (item.opcode == OP_RETUNE)
        begin
            for (int i = 0; i < NAME_LEN; i++)
            begin
                state_next.confirmed[i] = SPACE_CHAR;
            end
            state_next.seen = 1'b0;
        end
    end

    always_comb
    begin
        // character 0 goes to the top byte
        for (int i = 0; i < NAME_LEN; i++)
        begin
            result.station_name[NAME_W-1-CHAR_W*i -: CHAR_W] = state_next.confirmed[i];
        end
        result.name_valid = state_next.seen;
        result.group_used = do_group;
    end

endmodule

// ----- src/rdsps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsps_checker
// Port-level checks on the name assembler, bound to the top level.
// ----------------------------------------------------------------------------
module rdsps_checker
    import rdsps_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    localparam logic [NAME_W-1:0] ALL_SPACES = {NAME_LEN{SPACE_CHAR}};

    // a stalled result word keeps its payload
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // input only backs up when a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // no confirmed character means the name is still blank
    a_blank_name: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == ALL_SPACES)
        else $error("name not blank while flag is clear");

endmodule

bind rds_station_name_assembler_core rdsps_checker u_rdsps_checker (.*);
